### src/assert_macros.svh
// Assertion macros for the RTL of the chained hash set.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CHS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/chs_pkg.sv
// Package of the chained hash set: sizes, codes, sequencer states and the
// structs passed between the sequencer, the slot RAM and the fill table.
// No dependencies.
`default_nettype none

package chs_pkg;

  // NUM_BUCKETS must be a power of two: the bucket is the low key bits.
  localparam int unsigned NUM_BUCKETS  = 16;
  localparam int unsigned BUCKET_DEPTH = 8;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned BKT_W     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned SLOT_W    = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(BUCKET_DEPTH + 1);
  localparam int unsigned NUM_SLOTS = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int unsigned ADDR_W    = $clog2(NUM_SLOTS);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_INS_SH,
    S_INS_WR,
    S_DEL_SH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [KEY_W-1:0]  wdata;
  } ram_req_t;

  typedef struct packed {
    logic             we;
    logic [BKT_W-1:0] bucket;
    logic [CNT_W-1:0] count;
  } fill_wr_t;

  typedef struct packed {
    status_e status;
    logic    is_member;
  } result_t;

  // Flat slot address of a slot within a bucket.
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [BKT_W-1:0]  bucket,
                                                  input logic [SLOT_W-1:0] slot);
    logic [ADDR_W-1:0] base;
    base = ADDR_W'(bucket) * ADDR_W'(BUCKET_DEPTH);
    return base + ADDR_W'(slot);
  endfunction

endpackage

`default_nettype wire

### src/chs_slot_ram.sv
// Slot memory of the chained hash set: one write and one read port,
// registered read data. Depends on chs_pkg.
`default_nettype none

module chs_slot_ram (
  input  logic                        clk_i,
  input  chs_pkg::ram_req_t           req_i,
  output logic [chs_pkg::KEY_W-1:0]   rd_data_o
);

  logic [chs_pkg::KEY_W-1:0] mem_q [chs_pkg::NUM_SLOTS];
  logic [chs_pkg::KEY_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

### src/chs_fill_table.sv
// Per-bucket key counts of the chained hash set, cleared by reset.
// Depends on chs_pkg.
`default_nettype none

module chs_fill_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  chs_pkg::fill_wr_t           wr_i,
  input  logic [chs_pkg::BKT_W-1:0]   rd_bucket_i,
  output logic [chs_pkg::CNT_W-1:0]   rd_count_o
);

  logic [chs_pkg::CNT_W-1:0] fill_q [chs_pkg::NUM_BUCKETS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(chs_pkg::NUM_BUCKETS); i++) begin
        fill_q[i] <= '0;
      end
    end else if (wr_i.we) begin
      fill_q[wr_i.bucket] <= wr_i.count;
    end
  end

  assign rd_count_o = fill_q[rd_bucket_i];

endmodule

`default_nettype wire

### src/chs_ctrl.sv
// Sequencer of the chained hash set: scans one bucket slot per cycle
// through a single key comparator, then shifts slots to insert or delete.
// Depends on chs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module chs_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [chs_pkg::CMD_W-1:0]   command_i,
  input  logic [chs_pkg::KEY_W-1:0]   key_i,
  output chs_pkg::ram_req_t           ram_o,
  input  logic [chs_pkg::KEY_W-1:0]   rd_data_i,
  output chs_pkg::fill_wr_t           fill_wr_o,
  output logic [chs_pkg::BKT_W-1:0]   fill_bucket_o,
  input  logic [chs_pkg::CNT_W-1:0]   fill_count_i,
  input  logic                        res_ready_i,
  output logic                        done_o,
  output chs_pkg::result_t            result_o
);

  chs_pkg::state_e state_q, state_d;
  chs_pkg::cmd_e   cmd_q, cmd_d;
  logic [chs_pkg::KEY_W-1:0]  key_q, key_d;
  logic [chs_pkg::CNT_W-1:0]  fill_q, fill_d;
  logic [chs_pkg::CNT_W-1:0]  pos_q, pos_d;
  logic [chs_pkg::SLOT_W-1:0] idx_q, idx_d;
  logic                       found_q, found_d;
  chs_pkg::result_t           res_q, res_d;

  logic [chs_pkg::BKT_W-1:0]  bkt;
  logic [chs_pkg::CNT_W-1:0]  idx_inc;
  logic [chs_pkg::SLOT_W-1:0] idx_dec;
  logic [chs_pkg::CNT_W-1:0]  fill_dec;
  logic [chs_pkg::CNT_W-1:0]  pos_inc;
  logic                       key_lt;
  logic                       key_eq;

  assign bkt      = key_q[chs_pkg::BKT_W-1:0];
  assign idx_inc  = chs_pkg::CNT_W'(idx_q) + chs_pkg::CNT_W'(1);
  assign idx_dec  = idx_q - chs_pkg::SLOT_W'(1);
  assign fill_dec = fill_q - chs_pkg::CNT_W'(1);
  assign pos_inc  = pos_q + chs_pkg::CNT_W'(1);

  // The one comparator: stored slot against the request key.
  assign key_lt = (rd_data_i < key_q);
  assign key_eq = (rd_data_i == key_q);

  assign fill_bucket_o = key_i[chs_pkg::BKT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    key_q   <= key_d;
    fill_q  <= fill_d;
    pos_q   <= pos_d;
    idx_q   <= idx_d;
    found_q <= found_d;
    res_q   <= res_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      chs_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (fill_count_i == '0) ? chs_pkg::S_DECIDE : chs_pkg::S_SCAN;
        end
      end
      chs_pkg::S_SCAN: begin
        if (!(key_lt && (idx_inc < fill_q))) begin
          state_d = chs_pkg::S_DECIDE;
        end
      end
      chs_pkg::S_DECIDE: begin
        case (cmd_q)
          chs_pkg::CMD_INSERT: begin
            if (found_q || (fill_q == chs_pkg::CNT_W'(chs_pkg::BUCKET_DEPTH))) begin
              state_d = chs_pkg::S_DONE;
            end else if (fill_q > pos_q) begin
              state_d = chs_pkg::S_INS_SH;
            end else begin
              state_d = chs_pkg::S_INS_WR;
            end
          end
          chs_pkg::CMD_DELETE: begin
            state_d = (found_q && (pos_inc < fill_q)) ? chs_pkg::S_DEL_SH : chs_pkg::S_DONE;
          end
          default: begin
            state_d = chs_pkg::S_DONE;
          end
        endcase
      end
      chs_pkg::S_INS_SH: begin
        if (!(chs_pkg::CNT_W'(idx_q) > pos_q)) begin
          state_d = chs_pkg::S_INS_WR;
        end
      end
      chs_pkg::S_INS_WR: begin
        state_d = chs_pkg::S_DONE;
      end
      chs_pkg::S_DEL_SH: begin
        if (!(idx_inc < fill_q)) begin
          state_d = chs_pkg::S_DONE;
        end
      end
      chs_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = chs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = chs_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath, memory requests and handshake outputs.
  always_comb begin
    cmd_d      = cmd_q;
    key_d      = key_q;
    fill_d     = fill_q;
    pos_d      = pos_q;
    idx_d      = idx_q;
    found_d    = found_q;
    res_d      = res_q;
    ram_o      = '0;
    fill_wr_o  = '0;
    in_stall_o = 1'b1;
    done_o     = 1'b0;
    case (state_q)
      chs_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_d   = chs_pkg::cmd_e'(command_i);
          key_d   = key_i;
          fill_d  = fill_count_i;
          idx_d   = '0;
          pos_d   = '0;
          found_d = 1'b0;
          if (fill_count_i != '0) begin
            ram_o.re    = 1'b1;
            ram_o.raddr = chs_pkg::slot_addr(key_i[chs_pkg::BKT_W-1:0], '0);
          end
        end
      end
      chs_pkg::S_SCAN: begin
        if (key_lt) begin
          if (idx_inc < fill_q) begin
            ram_o.re    = 1'b1;
            ram_o.raddr = chs_pkg::slot_addr(bkt, idx_inc[chs_pkg::SLOT_W-1:0]);
            idx_d       = idx_inc[chs_pkg::SLOT_W-1:0];
          end else begin
            pos_d   = fill_q;
            found_d = 1'b0;
          end
        end else begin
          pos_d   = chs_pkg::CNT_W'(idx_q);
          found_d = key_eq;
        end
      end
      chs_pkg::S_DECIDE: begin
        fill_wr_o.bucket = bkt;
        case (cmd_q)
          chs_pkg::CMD_INSERT: begin
            if (found_q) begin
              res_d.status    = chs_pkg::ST_PRESENT;
              res_d.is_member = 1'b1;
            end else if (fill_q == chs_pkg::CNT_W'(chs_pkg::BUCKET_DEPTH)) begin
              res_d.status    = chs_pkg::ST_FULL;
              res_d.is_member = 1'b0;
            end else begin
              res_d.status    = chs_pkg::ST_INSERTED;
              res_d.is_member = 1'b1;
              fill_wr_o.we    = 1'b1;
              fill_wr_o.count = fill_q + chs_pkg::CNT_W'(1);
              if (fill_q > pos_q) begin
                ram_o.re    = 1'b1;
                ram_o.raddr = chs_pkg::slot_addr(bkt, fill_dec[chs_pkg::SLOT_W-1:0]);
                idx_d       = fill_dec[chs_pkg::SLOT_W-1:0];
              end
            end
          end
          chs_pkg::CMD_DELETE: begin
            res_d.is_member = 1'b0;
            if (found_q) begin
              res_d.status    = chs_pkg::ST_DELETED;
              fill_wr_o.we    = 1'b1;
              fill_wr_o.count = fill_dec;
              if (pos_inc < fill_q) begin
                ram_o.re    = 1'b1;
                ram_o.raddr = chs_pkg::slot_addr(bkt, pos_inc[chs_pkg::SLOT_W-1:0]);
                idx_d       = pos_inc[chs_pkg::SLOT_W-1:0];
              end
            end else begin
              res_d.status = chs_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            res_d.status    = found_q ? chs_pkg::ST_PRESENT : chs_pkg::ST_NOT_FOUND;
            res_d.is_member = found_q;
          end
        endcase
      end
      chs_pkg::S_INS_SH: begin
        // Move the slot just read up by one, and fetch the one below it.
        ram_o.we    = 1'b1;
        ram_o.waddr = chs_pkg::slot_addr(bkt, idx_inc[chs_pkg::SLOT_W-1:0]);
        ram_o.wdata = rd_data_i;
        if (chs_pkg::CNT_W'(idx_q) > pos_q) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = chs_pkg::slot_addr(bkt, idx_dec);
          idx_d       = idx_dec;
        end
      end
      chs_pkg::S_INS_WR: begin
        ram_o.we    = 1'b1;
        ram_o.waddr = chs_pkg::slot_addr(bkt, pos_q[chs_pkg::SLOT_W-1:0]);
        ram_o.wdata = key_q;
      end
      chs_pkg::S_DEL_SH: begin
        // Move the slot just read down by one, and fetch the one above it.
        ram_o.we    = 1'b1;
        ram_o.waddr = chs_pkg::slot_addr(bkt, idx_dec);
        ram_o.wdata = rd_data_i;
        if (idx_inc < fill_q) begin
          ram_o.re    = 1'b1;
          ram_o.raddr = chs_pkg::slot_addr(bkt, idx_inc[chs_pkg::SLOT_W-1:0]);
          idx_d       = idx_inc[chs_pkg::SLOT_W-1:0];
        end
      end
      chs_pkg::S_DONE: begin
        done_o = res_ready_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign result_o = res_q;

  `CHS_ASSERT_IMP(a_fill_bound, fill_wr_o.we,
                  fill_wr_o.count <= chs_pkg::CNT_W'(chs_pkg::BUCKET_DEPTH),
                  "bucket count written beyond the bucket depth")
  `CHS_ASSERT_IMP(a_shift_ports, ram_o.we && ram_o.re, ram_o.waddr != ram_o.raddr,
                  "slot shift reads and writes the same slot")
  `CHS_ASSERT_NXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != chs_pkg::S_IDLE,
                  "accepted word did not start the sequencer")
  `CHS_ASSERT_IMP(a_done_ready, done_o, res_ready_i,
                  "result handed over while the output register is occupied")

endmodule

`default_nettype wire

### src/chained_hash_set_top.sv
// Top level of the chained hash set: sequencer, slot RAM, fill table and
// the output register. Depends on chs_pkg and the chs_* modules.
`default_nettype none

// A hash set of 32-bit unsigned keys held in chs_pkg::NUM_BUCKETS buckets of
// up to chs_pkg::BUCKET_DEPTH keys each, kept in ascending order without
// duplicates; the bucket is the low bits of the key, so the bucket count is a
// power of two. Each input word carries a command (insert, delete, query;
// code 3 acts as a query) and a key, and gives exactly one output word with a
// status and a membership flag. The block works on one word at a time and
// holds in_stall_o high while it does. A taken word is scanned against the
// stored keys of its bucket in ascending order, up to the first key that is
// not below it (the scan visits at most the bucket's count), and is then
// decided. A successful insert then moves the larger keys up and writes the
// new key, and a delete that finds its key moves the larger keys down; then
// the result is loaded. The next word is taken in the idle state that follows.
// The pace is set by the slot RAM, which gives one read and one write per
// cycle: the scan reads and compares one slot per cycle, and each shifted
// slot is read while the previous one is written. The result sits in an
// output register, so the next word is taken while it waits for the
// consumer. Bucket counts are cleared by reset, and no clearing pass runs: a
// slot is only read below its bucket's count.

module chained_hash_set_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [chs_pkg::CMD_W-1:0]       command_i,
  input  logic [chs_pkg::KEY_W-1:0]       key_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [chs_pkg::STATUS_W-1:0]    status_o,
  output logic                            is_member_o
);

  chs_pkg::ram_req_t          ram_req;
  logic [chs_pkg::KEY_W-1:0]  rd_data;
  chs_pkg::fill_wr_t          fill_wr;
  logic [chs_pkg::BKT_W-1:0]  fill_bucket;
  logic [chs_pkg::CNT_W-1:0]  fill_count;
  logic                       res_ready;
  logic                       done;
  chs_pkg::result_t           result;

  logic                       out_valid_q, out_valid_d;
  chs_pkg::result_t           out_res_q, out_res_d;

  chs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .key_i         (key_i),
    .ram_o         (ram_req),
    .rd_data_i     (rd_data),
    .fill_wr_o     (fill_wr),
    .fill_bucket_o (fill_bucket),
    .fill_count_i  (fill_count),
    .res_ready_i   (res_ready),
    .done_o        (done),
    .result_o      (result)
  );

  chs_slot_ram u_slot_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  chs_fill_table u_fill_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (fill_wr),
    .rd_bucket_i (fill_bucket),
    .rd_count_o  (fill_count)
  );

  // The output register is free when empty or when its word leaves now.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (done) begin
      out_valid_d = 1'b1;
      out_res_d   = result;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_res_q.status;
  assign is_member_o = out_res_q.is_member;

endmodule

`default_nettype wire
